// ===== rtl/core/zero_run_length_decoder_core_assert.svh =====
// Assertion macros for the checker file.
`ifndef ZERO_RUN_LENGTH_DECODER_CORE_ASSERT_SVH
`define ZERO_RUN_LENGTH_DECODER_CORE_ASSERT_SVH

// Check a property on every rising clk edge outside reset.
`define ZRLD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define ZRLD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/zrld_pkg.sv =====
package zrld_pkg;

  localparam int MAX_RUN_DIGITS = 24;
  localparam int RUN_SUM_BITS   = 24;
  localparam int ZERO_RUN_BITS  = 25;
  localparam int COUNT_BITS     = 5;

  // Digits accepted per run before the rest are dropped.
  localparam logic [COUNT_BITS-1:0] DIGIT_CAP =
    COUNT_BITS'((MAX_RUN_DIGITS < RUN_SUM_BITS) ? MAX_RUN_DIGITS : RUN_SUM_BITS);

  localparam logic [7:0] ESCAPE_BYTE = 8'hFF;
  localparam logic [7:0] ESC_LOW     = 8'hFE;
  localparam logic [7:0] ESC_HIGH    = 8'hFF;

  typedef struct packed {
    logic [RUN_SUM_BITS-1:0] run_sum;
    logic [COUNT_BITS-1:0]   digit_count;
    logic                    escape_pending;
    logic                    overflow_seen;
  } zrld_state_t;

  typedef struct packed {
    logic                     emit;
    logic [ZERO_RUN_BITS-1:0] zero_run;
    logic                     has_byte;
    logic [7:0]               decoded_byte;
    logic                     chunk_done;
    logic                     run_overflow;
  } zrld_result_t;

endpackage

// ===== rtl/core/zrld_decode.sv =====
module zrld_decode
  import zrld_pkg::*;
(
  input  zrld_state_t  state,
  input  logic [7:0]   in_byte,
  input  logic         end_of_chunk,
  output zrld_result_t result,
  output zrld_state_t  state_next
);

  logic                     esc;
  logic                     is_digit;
  logic                     esc_start;
  logic                     literal;
  logic                     take_digit;
  logic [RUN_SUM_BITS-1:0]  sum_upd;
  logic [COUNT_BITS-1:0]    count_upd;
  logic                     ovf_upd;
  logic                     has;
  logic                     flush;
  logic                     run_out;
  logic [ZERO_RUN_BITS-1:0] zeros;
  logic [7:0]               byte_val;

  // Classify the byte against the escape state.
  assign esc       = state.escape_pending;
  assign is_digit  = !esc && (in_byte[7:1] == 7'd0);
  assign esc_start = !esc && (in_byte == ESCAPE_BYTE);
  assign literal   = !esc && !is_digit && !esc_start;

  // Append a digit to the open run, or mark it dropped past the cap.
  assign take_digit = is_digit && (state.digit_count < DIGIT_CAP);
  assign sum_upd    = take_digit ?
                      (state.run_sum | (RUN_SUM_BITS'(in_byte[0]) << state.digit_count)) :
                      state.run_sum;
  assign count_upd  = take_digit ? state.digit_count + COUNT_BITS'(1) : state.digit_count;
  assign ovf_upd    = state.overflow_seen || (is_digit && !take_digit);

  // Decode the literal or the escaped byte.
  assign has      = (esc && (in_byte[7:1] == 7'd0)) || literal;
  assign byte_val = esc ? (in_byte[0] ? ESC_HIGH : ESC_LOW) : (in_byte - 8'd1);

  // Flush the run on a literal, on an escaped byte or at chunk end; an escape byte alone does not flush.
  assign flush   = esc || literal || end_of_chunk;
  assign run_out = flush && (count_upd != '0);
  assign zeros   = (ZERO_RUN_BITS'(1) << count_upd) + ZERO_RUN_BITS'(sum_upd)
                   - ZERO_RUN_BITS'(1);

  always_comb begin
    result.emit         = run_out || has || end_of_chunk;
    result.zero_run     = run_out ? zeros : '0;
    result.has_byte     = has;
    result.decoded_byte = has ? byte_val : 8'd0;
    result.chunk_done   = end_of_chunk;
    result.run_overflow = run_out && ovf_upd;
  end

  // Clear everything at chunk end, the run alone after a flush.
  always_comb begin
    state_next.run_sum        = sum_upd;
    state_next.digit_count    = count_upd;
    state_next.overflow_seen  = ovf_upd;
    state_next.escape_pending = esc_start && !end_of_chunk;
    if (run_out || end_of_chunk) begin
      state_next.run_sum       = '0;
      state_next.digit_count   = '0;
      state_next.overflow_seen = 1'b0;
    end
  end

endmodule

// ===== rtl/core/zero_run_length_decoder_core.sv =====
// Zero run-length decoder core.
// Input channel: in_valid / in_stall carry one coded byte per beat (in_byte)
// plus end_of_chunk on the final byte of a chunk. Digit bytes 0 and 1 build
// a run; escape 0xFF takes the next byte; other bytes decode to byte - 1.
// Output channel: out_valid / out_stall carry at most one result beat per
// input beat: zero_run (zeros to emit first), has_byte and decoded_byte,
// chunk_done on the final result of a chunk, run_overflow when a run had
// more digits than the cap. Beats that close nothing give no result.
// Path: an accepted input beat is held in the input register, decoded by the
// single decode step, then registered in the result register. Throughput: one
// input beat per cycle unless a beat that needs a result meets a stall.
// Stall: when out_stall holds a full result register, the input register
// still drains beats that give no result; a beat that needs the result
// register waits, and in_stall rises in the same cycle.
// Reset (rst, synchronous) empties both registers and clears the run and
// escape state; decoding starts fresh with the next beat.
module zero_run_length_decoder_core
  import zrld_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_byte,
  input  logic                     end_of_chunk,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [ZERO_RUN_BITS-1:0] zero_run,
  output logic                     has_byte,
  output logic [7:0]               decoded_byte,
  output logic                     chunk_done,
  output logic                     run_overflow
);

  logic         hold_valid;
  logic [7:0]   hold_byte;
  logic         hold_eoc;
  zrld_state_t  state;
  zrld_state_t  state_next;
  zrld_result_t result;
  logic         out_free;
  logic         hold_take;
  logic         in_beat;

  zrld_decode u_decode (
    .state        (state),
    .in_byte      (hold_byte),
    .end_of_chunk (hold_eoc),
    .result       (result),
    .state_next   (state_next)
  );

  // Retire the held beat when it needs no result or the result register is free.
  assign out_free  = !out_valid || !out_stall;
  assign hold_take = hold_valid && (!result.emit || out_free);
  assign in_stall  = hold_valid && !hold_take;
  assign in_beat   = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_beat) begin
      hold_valid <= 1'b1;
    end else if (hold_take) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      hold_byte <= in_byte;
      hold_eoc  <= end_of_chunk;
    end
  end

  // Advance the run and escape state per retired beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (hold_take) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= hold_valid && result.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && hold_valid && result.emit) begin
      zero_run     <= result.zero_run;
      has_byte     <= result.has_byte;
      decoded_byte <= result.decoded_byte;
      chunk_done   <= result.chunk_done;
      run_overflow <= result.run_overflow;
    end
  end

endmodule

// ===== rtl/core/zrld_checker.sv =====
`include "zero_run_length_decoder_core_assert.svh"

module zrld_checker
  import zrld_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic [7:0]               in_byte,
  input logic                     end_of_chunk,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [ZERO_RUN_BITS-1:0] zero_run,
  input logic                     has_byte,
  input logic [7:0]               decoded_byte,
  input logic                     chunk_done,
  input logic                     run_overflow
);

  logic                      in_held;
  logic [8:0]                in_word;
  logic                      out_held;
  logic [ZERO_RUN_BITS+10:0] out_word;

  // Gather each channel's payload into one word.
  assign in_held  = in_valid && in_stall;
  assign in_word  = {in_byte, end_of_chunk};
  assign out_held = out_valid && out_stall;
  assign out_word = {zero_run, has_byte, decoded_byte, chunk_done, run_overflow};

  // A stalled input beat stays put.
  `ZRLD_ASSERT(a_in_hold, in_held |=> in_valid && $stable(in_word), "stalled input beat changed")

  // A stalled result beat stays put.
  `ZRLD_ASSERT(a_out_hold, out_held |=> out_valid && $stable(out_word), "stalled beat changed")

  // Every result beat carries a run, a byte or a chunk end.
  `ZRLD_ASSERT(a_out_content, out_valid |-> (zero_run != '0) || has_byte || chunk_done, "empty result beat")

  // An overflow only comes with a flushed run.
  `ZRLD_ASSERT(a_ovf_run, out_valid && run_overflow |-> zero_run != '0, "overflow without a run")

  // No decoded byte leaks out when has_byte is low.
  `ZRLD_ASSERT(a_byte_clear, out_valid && !has_byte |-> decoded_byte == 8'd0, "byte set without has_byte")

endmodule

bind zero_run_length_decoder_core zrld_checker u_zrld_checker (.*);
